// File: rtl/kdb_pkg.sv
package kdb_pkg;

    // Width of the tick counter shared by debounce, hold and repeat timing.
    localparam int COUNT_WIDTH = 16;
    localparam int REG_WIDTH   = 16;
    // Compare width covers both the counter and the 16-bit registers.
    localparam int CMP_WIDTH   = (COUNT_WIDTH > REG_WIDTH) ? COUNT_WIDTH : REG_WIDTH;

    localparam logic [2:0] KEY_NONE  = 3'd0;
    localparam logic [2:0] KEY_B1    = 3'd1;
    localparam logic [2:0] KEY_B2    = 3'd2;
    localparam logic [2:0] KEY_B3    = 3'd3;
    localparam logic [2:0] KEY_B4    = 3'd4;
    localparam logic [2:0] KEY_COMBO = 3'd5;

    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_PRESS  = 2'd1;
    localparam logic [1:0] EV_HOLD   = 2'd2;
    localparam logic [1:0] EV_REPEAT = 2'd3;

    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_HOLD     = 2'd1;
    localparam logic [1:0] REG_REPEAT   = 2'd2;

    localparam logic [REG_WIDTH-1:0] DEBOUNCE_RESET = 16'd40;
    localparam logic [REG_WIDTH-1:0] HOLD_RESET     = 16'd1000;
    localparam logic [REG_WIDTH-1:0] REPEAT_RESET   = 16'd100;

    typedef struct packed {
        logic [REG_WIDTH-1:0] debounce_ticks;
        logic [REG_WIDTH-1:0] hold_ticks;
        logic [REG_WIDTH-1:0] repeat_ticks;
    } t_cfg;

    typedef struct packed {
        logic [1:0] event_res;
        logic [2:0] key;
    } t_result;

    // Button 1 wins over 2, 2 over 3, 3 over 4; buttons 3 and 4 together
    // give the combo code.
    function automatic logic [2:0] encode_keys(input logic [3:0] b);
        logic [2:0] code;
        if (b[0]) begin
            code = KEY_B1;
        end else if (b[1]) begin
            code = KEY_B2;
        end else if (b[2]) begin
            code = KEY_B3;
        end else if (b[3]) begin
            code = KEY_B4;
        end else begin
            code = KEY_NONE;
        end
        if (b[3] && b[2]) begin
            code = KEY_COMBO;
        end
        return code;
    endfunction

endpackage

// File: rtl/key_debounce_press_hold_repeat.sv
// Debounced four-button keypad with short press, hold and auto-repeat.
//
// Slave stream: one request per tick, i_s_axis_tdata[3:0] holds the four
// button levels (bit0 is button 1, 1 means pressed). Master stream: one
// result per request, o_m_axis_tdata[1:0] is the event (none, short press,
// hold, repeat) and [4:2] the key code, zero when there is no event.
// Configuration: i_cfg_we with i_cfg_index 0/1/2 writes debounce, hold and
// repeat tick counts; write only while no request is in flight.
//
// A request accepted at one edge shows its result on the master side
// in the next cycle, from the result register. Throughput: one request
// every cycle while results are taken; the step logic and the single
// result register set that figure. When the receiver stalls, the result
// register holds; the slave side accepts only in a cycle that takes it.
// Reset (synchronous, active low) returns the machine to idle, clears the
// tick counter and pending press, drops the output valid and loads the
// register defaults 40, 1000 and 100.
module key_debounce_press_hold_repeat (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [3:0] buttons, [7:4] zero
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata    // [1:0] event_res, [4:2] key, [7:5] zero
);
    import kdb_pkg::*;

    t_cfg    r_cfg;
    t_result step_result;
    t_result r_result;
    logic    r_out_valid;
    logic    accept;

    // hold the result until taken; free the register when it drains
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks <= DEBOUNCE_RESET;
            r_cfg.hold_ticks     <= HOLD_RESET;
            r_cfg.repeat_ticks   <= REPEAT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DEBOUNCE: r_cfg.debounce_ticks <= i_cfg_data;
                REG_HOLD:     r_cfg.hold_ticks     <= i_cfg_data;
                REG_REPEAT:   r_cfg.repeat_ticks   <= i_cfg_data;
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    kdb_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (accept),
        .i_buttons (i_s_axis_tdata[3:0]),
        .i_cfg     (r_cfg),
        .o_result  (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= step_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_result.key, r_result.event_res};

    // A stalled result blocks the slave side.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("request accepted while result is stalled");

    // Every accepted request yields a valid result next cycle.
    a_accept_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> o_m_axis_tvalid)
        else $error("accepted request produced no result");

    // No event means key code zero; an event never carries key zero.
    a_key_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ((o_m_axis_tdata[1:0] == EV_NONE) == (o_m_axis_tdata[4:2] == KEY_NONE)))
        else $error("event and key code disagree");

    // Output is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

// File: rtl/kdb_core.sv
module kdb_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [3:0]       i_buttons,
    input  kdb_pkg::t_cfg    i_cfg,
    output kdb_pkg::t_result o_result
);
    import kdb_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_DEBOUNCE = 5'b00010,
        PH_CONFIRM  = 5'b00100,
        PH_PRESSED  = 5'b01000,
        PH_REPEAT   = 5'b10000
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic                   r_press_pending, n_press_pending;
    logic [2:0]             r_latched_key, n_latched_key;
    logic [COUNT_WIDTH-1:0] r_tick_count, n_tick_count;

    logic [2:0]           code;
    logic                 restart;
    logic                 same_key;
    logic [CMP_WIDTH-1:0] cnt_ext, deb_ext, hold_ext, rep_ext;

    assign code     = encode_keys(i_buttons);
    assign same_key = (code == r_latched_key);
    assign cnt_ext  = CMP_WIDTH'(r_tick_count);
    assign deb_ext  = CMP_WIDTH'(i_cfg.debounce_ticks);
    assign hold_ext = CMP_WIDTH'(i_cfg.hold_ticks);
    assign rep_ext  = CMP_WIDTH'(i_cfg.repeat_ticks);

    always_comb begin
        n_phase         = r_phase;
        n_press_pending = r_press_pending;
        n_latched_key   = r_latched_key;
        restart         = 1'b0;
        o_result        = '{event_res: EV_NONE, key: KEY_NONE};
        case (r_phase)
            PH_IDLE: begin
                // report a short press left pending by the last release
                if (r_press_pending) begin
                    o_result        = '{event_res: EV_PRESS, key: r_latched_key};
                    n_press_pending = 1'b0;
                end
                if (code != KEY_NONE) begin
                    n_latched_key = code;
                    restart       = 1'b1;
                    n_phase       = PH_DEBOUNCE;
                end
            end
            PH_DEBOUNCE: begin
                if (cnt_ext > deb_ext) begin
                    n_press_pending = 1'b0;
                    n_phase         = PH_CONFIRM;
                end
            end
            PH_CONFIRM: begin
                if (same_key) begin
                    restart         = 1'b1;
                    n_press_pending = 1'b1;
                    n_phase         = PH_PRESSED;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_PRESSED: begin
                if (!same_key) begin
                    n_phase = PH_IDLE;
                end else if (cnt_ext >= hold_ext) begin
                    restart         = 1'b1;
                    o_result        = '{event_res: EV_HOLD, key: code};
                    n_press_pending = 1'b0;
                    n_phase         = PH_REPEAT;
                end
            end
            PH_REPEAT: begin
                if (!same_key) begin
                    n_phase = PH_IDLE;
                end else if (cnt_ext >= rep_ext) begin
                    restart         = 1'b1;
                    o_result        = '{event_res: EV_REPEAT, key: code};
                    n_press_pending = 1'b0;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        // restart clears, otherwise advance and saturate
        if (restart) begin
            n_tick_count = '0;
        end else if (r_tick_count != {COUNT_WIDTH{1'b1}}) begin
            n_tick_count = r_tick_count + 1'b1;
        end else begin
            n_tick_count = r_tick_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_press_pending <= 1'b0;
            r_latched_key   <= KEY_NONE;
            r_tick_count    <= '0;
        end else if (i_step) begin
            r_phase         <= n_phase;
            r_press_pending <= n_press_pending;
            r_latched_key   <= n_latched_key;
            r_tick_count    <= n_tick_count;
        end
    end

endmodule
